FILE: design/adaptive_threshold_neuron_step_core_macros.svh
// Assertion macros used by the checker file of the neuron step core.
`ifndef ADAPTIVE_THRESHOLD_NEURON_STEP_CORE_MACROS_SVH
`define ADAPTIVE_THRESHOLD_NEURON_STEP_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ATN_ASSERT_IMPLY(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define ATN_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Delayed implication, disabled during reset.
`define ATN_ASSERT_LAT2(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##2 (cons)) \
        else $error(msg);

`endif

FILE: design/atn_pkg.sv
// ----------------------------------------------------------------------------
// atn_pkg
// Shared widths, register indexes and types of the neuron step core.
// ----------------------------------------------------------------------------
package atn_pkg;

    localparam int ACH_W      = 22;
    localparam int OUT_VAL_W  = 24;
    localparam int STATE_W    = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    localparam logic [CFG_IDX_W-1:0] CFG_MODEL_MODE        = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_EXC_GAIN          = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PULSE_TICKS       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DECAY_STEP        = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PULSE_RISE        = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_INPUT_RISE        = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_FEED_STEP         = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_THRESHOLD = 3'd7;

    localparam logic [23:0] INIT_THRESHOLD_RESET = 24'd131072;

    typedef struct packed {
        logic        model_mode;
        logic [15:0] exc_gain;
        logic [15:0] pulse_ticks;
        logic [15:0] decay_step;
        logic [15:0] pulse_rise;
        logic [15:0] input_rise;
        logic [15:0] feed_step;
    } cfg_t;

    typedef struct packed {
        logic [STATE_W-1:0]   cell_state;
        logic                 state_changed;
        logic [OUT_VAL_W-1:0] excitation_out;
        logic [OUT_VAL_W-1:0] threshold_out;
    } res_t;

endpackage

FILE: design/atn_ach_if.sv
// ----------------------------------------------------------------------------
// atn_ach_if
// Input channel: one tick of summed neighbour excitation per transaction.
// ----------------------------------------------------------------------------
interface atn_ach_if
    import atn_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [ACH_W-1:0] ach_input;

    modport source (output valid, output ach_input, input ready);
    modport sink (input valid, input ach_input, output ready);
endinterface

FILE: design/atn_result_if.sv
// ----------------------------------------------------------------------------
// atn_result_if
// Result channel: cell state and values after one tick per transaction.
// ----------------------------------------------------------------------------
interface atn_result_if
    import atn_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [STATE_W-1:0]   cell_state;
    logic                 state_changed;
    logic [OUT_VAL_W-1:0] excitation_out;
    logic [OUT_VAL_W-1:0] threshold_out;

    modport source (output valid, output cell_state, output state_changed,
                    output excitation_out, output threshold_out, input ready);
    modport sink (input valid, input cell_state, input state_changed,
                  input excitation_out, input threshold_out, output ready);
endinterface

FILE: design/atn_cfg_regs.sv
// ----------------------------------------------------------------------------
// atn_cfg_regs
// Configuration register file written through a plain write port.
// ----------------------------------------------------------------------------
module atn_cfg_regs
    import atn_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_MODEL_MODE:        cfg_next.model_mode  = cfg_wdata[0];
                CFG_EXC_GAIN:          cfg_next.exc_gain    = cfg_wdata[15:0];
                CFG_PULSE_TICKS:       cfg_next.pulse_ticks = cfg_wdata[15:0];
                CFG_DECAY_STEP:        cfg_next.decay_step  = cfg_wdata[15:0];
                CFG_PULSE_RISE:        cfg_next.pulse_rise  = cfg_wdata[15:0];
                CFG_INPUT_RISE:        cfg_next.input_rise  = cfg_wdata[15:0];
                CFG_FEED_STEP:         cfg_next.feed_step   = cfg_wdata[15:0];
                // The initial threshold is not stored; reset loads a constant.
                CFG_INITIAL_THRESHOLD: cfg_next = cfg_reg;
                default:               cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.model_mode  <= 1'b0;
            cfg_reg.exc_gain    <= 16'd6554;
            cfg_reg.pulse_ticks <= 16'd100;
            cfg_reg.decay_step  <= 16'd16;
            cfg_reg.pulse_rise  <= 16'd655;
            cfg_reg.input_rise  <= 16'd655;
            cfg_reg.feed_step   <= 16'd655;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

FILE: design/atn_neuron.sv
// ----------------------------------------------------------------------------
// atn_neuron
// Cell state, excitation, threshold, pending rise and countdown, advanced by
// one tick whenever step is high.
// ----------------------------------------------------------------------------
module atn_neuron
    import atn_pkg::*;
#(
    parameter int HOLD_TICKS = 300,
    parameter int VALUE_BITS = 24
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             step,
    input  logic [ACH_W-1:0] ach,
    input  cfg_t             cfg,
    output res_t             res
);

    localparam int VB = VALUE_BITS;
    localparam int AW = (VB > ACH_W) ? VB : ACH_W;
    localparam int UW = ((VB > ACH_W + 1) ? VB : ACH_W + 1) + 1;
    localparam logic [63:0] VAL_MAX64 = (64'd1 << VALUE_BITS) - 64'd1;
    localparam logic [VB-1:0] THR_RESET =
        VB'((64'(INIT_THRESHOLD_RESET) > VAL_MAX64) ? VAL_MAX64 : 64'(INIT_THRESHOLD_RESET));
    localparam logic [15:0] HOLD_LOAD = 16'(HOLD_TICKS);

    typedef enum logic [STATE_W-1:0] {
        QUIET = 2'd0,
        PULSE = 2'd1,
        BURST = 2'd2
    } cell_st_t;

    cell_st_t       state_reg, state_next;
    logic [VB-1:0]  exc_reg, exc_next;
    logic [VB-1:0]  thr_reg, thr_next;
    logic [VB-1:0]  pend_reg, pend_next;
    logic [15:0]    cd_reg, cd_next;

    logic           expired;
    logic [15:0]    cd_dec;
    logic [AW-1:0]  ach_w, exc_w, diff;
    logic           ach_ge;
    logic [AW+15:0] exc_prod;
    logic [AW-1:0]  exc_step;
    logic [AW:0]    exc_sum;
    logic [VB-1:0]  int_exc;
    logic           above;
    logic [ACH_W+15:0] in_prod;
    logic [ACH_W-1:0]  in_term;
    logic [ACH_W:0]    act_rise;
    logic [ACH_W:0]    rise;
    logic [UW-1:0]  pend_sum;
    logic [VB-1:0]  pend_sat, feed;
    logic [ACH_W:0] thr_up;
    logic [UW-1:0]  thr_sum;
    logic [VB-1:0]  thr_sat, decay_w;
    logic [VB+OUT_VAL_W-1:0] exc_ext, thr_ext;

    always_comb
    begin
        expired = (cd_reg == 16'd0);
        cd_dec  = expired ? cd_reg : cd_reg - 16'd1;

        ach_w    = AW'(ach);
        exc_w    = AW'(exc_reg);
        ach_ge   = (ach_w >= exc_w);
        diff     = ach_ge ? ach_w - exc_w : exc_w - ach_w;
        exc_prod = (AW+16)'(diff) * (AW+16)'(cfg.exc_gain);
        exc_step = exc_prod[AW+15:16];
        exc_sum  = (AW+1)'(exc_w) + (AW+1)'(exc_step);
        if (ach_ge)
        begin
            int_exc = (exc_sum[AW:VB] != '0) ? '1 : exc_sum[VB-1:0];
        end
        else
        begin
            int_exc = exc_reg - exc_step[VB-1:0];
        end
        above = (int_exc >= thr_reg);

        in_prod  = (ACH_W+16)'(ach) * (ACH_W+16)'(cfg.input_rise);
        in_term  = in_prod[ACH_W+15:16];
        act_rise = (ACH_W+1)'(cfg.pulse_rise) + (ACH_W+1)'(in_term);

        state_next = state_reg;
        cd_next    = cd_dec;
        exc_next   = int_exc;
        pend_next  = pend_reg;
        rise       = '0;
        pend_sum   = '0;
        pend_sat   = '0;
        feed       = '0;

        if (!cfg.model_mode)
        begin
            if (state_reg != QUIET)
            begin
                exc_next = expired ? '0 : exc_reg;
                if (expired)
                begin
                    state_next = QUIET;
                end
            end
            else if (above)
            begin
                state_next = PULSE;
                cd_next    = cfg.pulse_ticks;
            end
            thr_up = (state_next != QUIET) ? act_rise : '0;
        end
        else
        begin
            unique case (state_reg)
                PULSE:
                begin
                    if (expired)
                    begin
                        state_next = above ? BURST : QUIET;
                        cd_next    = HOLD_LOAD;
                    end
                end
                BURST:
                begin
                    if (!above)
                    begin
                        state_next = QUIET;
                    end
                    else if (expired)
                    begin
                        state_next = PULSE;
                        cd_next    = cfg.pulse_ticks;
                    end
                end
                default:
                begin
                    if (above)
                    begin
                        if (expired)
                        begin
                            state_next = PULSE;
                            cd_next    = cfg.pulse_ticks;
                        end
                        else
                        begin
                            state_next = BURST;
                        end
                    end
                end
            endcase

            if (state_next == PULSE)
            begin
                rise = act_rise;
            end
            else if (state_next == BURST)
            begin
                rise = (ACH_W+1)'(in_term);
            end
            pend_sum  = UW'(pend_reg) + UW'(rise);
            pend_sat  = (pend_sum[UW-1:VB] != '0) ? '1 : pend_sum[VB-1:0];
            feed      = (pend_sat < VB'(cfg.feed_step)) ? pend_sat : VB'(cfg.feed_step);
            pend_next = pend_sat - feed;
            thr_up    = (ACH_W+1)'(feed[15:0]);
        end

        decay_w  = VB'(cfg.decay_step);
        thr_sum  = UW'(thr_reg) + UW'(thr_up);
        thr_sat  = (thr_sum[UW-1:VB] != '0) ? '1 : thr_sum[VB-1:0];
        thr_next = (thr_sat > decay_w) ? thr_sat - decay_w : '0;

        exc_ext = (VB+OUT_VAL_W)'(exc_next);
        thr_ext = (VB+OUT_VAL_W)'(thr_next);

        res.cell_state     = state_next;
        res.state_changed  = (state_next != state_reg);
        res.excitation_out = exc_ext[OUT_VAL_W-1:0];
        res.threshold_out  = thr_ext[OUT_VAL_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= QUIET;
            exc_reg   <= '0;
            thr_reg   <= THR_RESET;
            pend_reg  <= '0;
            cd_reg    <= '0;
        end
        else if (step)
        begin
            state_reg <= state_next;
            exc_reg   <= exc_next;
            thr_reg   <= thr_next;
            pend_reg  <= pend_next;
            cd_reg    <= cd_next;
        end
    end

endmodule

FILE: design/adaptive_threshold_neuron_step_core.sv
// ----------------------------------------------------------------------------
// adaptive_threshold_neuron_step_core
// Adaptive-threshold neuron advanced by one simulation tick per transaction.
//
//   Channel   Dir  Payload                                         Per item
//   ach_ch    in   ach_input                                       one tick
//   result_ch out  cell_state, state_changed, excitation_out,
//                  threshold_out                                   one result
//
// One transaction is accepted every cycle while the result side does not
// stall. Each input is held in the input register, the tick update runs
// combinationally, and the result is stored in the result register.
// Reset restores every register but ach_reg and res_reg to its reset value.
// A stalled result holds in the result register while one further input waits
// in the input register; the input stalls only when both are full.
// ----------------------------------------------------------------------------
module adaptive_threshold_neuron_step_core
    import atn_pkg::*;
#(
    parameter int HOLD_TICKS = 300,
    parameter int VALUE_BITS = 24
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    atn_ach_if.sink               ach_ch,
    atn_result_if.source          result_ch,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    cfg_t             cfg;
    res_t             tick_res;
    logic             in_valid_reg, in_valid_next;
    logic [ACH_W-1:0] ach_reg;
    logic             out_valid_reg, out_valid_next;
    res_t             res_reg;
    logic             advance;
    logic             in_take;

    atn_cfg_regs u_cfg_regs
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    atn_neuron
    #(
        .HOLD_TICKS (HOLD_TICKS),
        .VALUE_BITS (VALUE_BITS)
    )
    u_neuron
    (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (advance),
        .ach   (ach_reg),
        .cfg   (cfg),
        .res   (tick_res)
    );

    always_comb
    begin
        advance      = in_valid_reg && (!out_valid_reg || result_ch.ready);
        ach_ch.ready = !in_valid_reg || advance;
        in_take      = ach_ch.valid && ach_ch.ready;

        in_valid_next = in_valid_reg;
        if (in_take)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (result_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            ach_reg <= ach_ch.ach_input;
        end
        if (advance)
        begin
            res_reg <= tick_res;
        end
    end

    assign result_ch.valid          = out_valid_reg;
    assign result_ch.cell_state     = res_reg.cell_state;
    assign result_ch.state_changed  = res_reg.state_changed;
    assign result_ch.excitation_out = res_reg.excitation_out;
    assign result_ch.threshold_out  = res_reg.threshold_out;

endmodule

FILE: design/atn_checker.sv
// ----------------------------------------------------------------------------
// atn_checker
// Port-level checks of the neuron step core, bound to the top level.
// ----------------------------------------------------------------------------
`include "adaptive_threshold_neuron_step_core_macros.svh"

module atn_checker
    import atn_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 in_valid,
    input logic                 in_ready,
    input logic                 out_valid,
    input logic                 out_ready,
    input logic [STATE_W-1:0]   cell_state,
    input logic                 state_changed,
    input logic [OUT_VAL_W-1:0] excitation_out,
    input logic [OUT_VAL_W-1:0] threshold_out
);

    `ATN_ASSERT_NEXT(a_result_holds, clk, rst_n, out_valid && !out_ready, out_valid && $stable({cell_state, state_changed, excitation_out, threshold_out}), "stalled result transaction changed")
    `ATN_ASSERT_IMPLY(a_state_code, clk, rst_n, out_valid, !(cell_state[1] && cell_state[0]), "result carries an unused state code")
    `ATN_ASSERT_IMPLY(a_ready_when_empty, clk, rst_n, !out_valid, in_ready, "input stalled with an empty result register")
    `ATN_ASSERT_LAT2(a_result_latency, clk, rst_n, in_valid && in_ready, out_valid, "no result two cycles after an input transaction")

endmodule

bind adaptive_threshold_neuron_step_core atn_checker u_atn_checker
(
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (ach_ch.valid),
    .in_ready       (ach_ch.ready),
    .out_valid      (result_ch.valid),
    .out_ready      (result_ch.ready),
    .cell_state     (result_ch.cell_state),
    .state_changed  (result_ch.state_changed),
    .excitation_out (result_ch.excitation_out),
    .threshold_out  (result_ch.threshold_out)
);

FILE: bench/tb_adaptive_threshold_neuron_step_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_adaptive_threshold_neuron_step_core
// Self-checking bench for the adaptive-threshold neuron step core.
//
// Ticks are sent one transaction at a time, and each accepted tick is run
// through a cycle-free model of the cell that keeps its own copy of the
// state and the registers. The expected result is queued. Every result
// transaction is compared field by field with the oldest queued entry.
// Short directed sequences cover pulse, burst, clamping and saturation.
// Segmented random drive follows under several register settings, with
// random gaps on both channels, a long result stall and a full drain.
// ----------------------------------------------------------------------------
module tb_adaptive_threshold_neuron_step_core;
    import atn_pkg::*;

    localparam int HOLD_TICKS = 300;
    localparam int VALUE_BITS = 24;
    localparam longint unsigned VALUE_MAX = (64'd1 << VALUE_BITS) - 64'd1;
    localparam logic [ACH_W-1:0] ACH_MAX = '1;
    localparam logic [STATE_W-1:0] CELL_QUIET = 2'd0;
    localparam logic [STATE_W-1:0] CELL_PULSE = 2'd1;
    localparam logic [STATE_W-1:0] CELL_BURST = 2'd2;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 4;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    atn_ach_if    ach_ch();
    atn_result_if result_ch();

    adaptive_threshold_neuron_step_core #(
        .HOLD_TICKS(HOLD_TICKS),
        .VALUE_BITS(VALUE_BITS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .ach_ch(ach_ch),
        .result_ch(result_ch),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata)
    );

    cfg_t                cell_cfg;
    logic [STATE_W-1:0]  cell_st;
    longint unsigned     cell_exc;
    longint unsigned     cell_thr;
    longint unsigned     cell_pend;
    logic [15:0]         cell_countdown;

    res_t predicted_ticks[$];
    int   tick_mismatches;
    int   cycle_count;
    bit   tx_steady;
    bit   rx_steady;
    int   rx_hold_cycles;

    always #5 clk = ~clk;

    function automatic longint unsigned clip_value(longint unsigned v);
        return (v > VALUE_MAX) ? VALUE_MAX : v;
    endfunction

    function automatic void leak_toward(longint unsigned a);
        if (a >= cell_exc)
        begin
            cell_exc = clip_value(cell_exc +
                                  (((a - cell_exc) * 64'(cell_cfg.exc_gain)) >> 16));
        end
        else
        begin
            cell_exc = cell_exc - (((cell_exc - a) * 64'(cell_cfg.exc_gain)) >> 16);
        end
    endfunction

    function automatic void settle_threshold(longint unsigned up);
        longint unsigned t;
        t = clip_value(cell_thr + up);
        cell_thr = (t > 64'(cell_cfg.decay_step)) ? t - 64'(cell_cfg.decay_step) : 64'd0;
    endfunction

    function automatic res_t advance_cell(logic [ACH_W-1:0] ach);
        longint unsigned    a;
        longint unsigned    in_term;
        longint unsigned    rise;
        longint unsigned    feed;
        logic [STATE_W-1:0] prior;
        logic               expired;
        logic               above;
        res_t               r;
        a = 64'(ach);
        prior = cell_st;
        expired = (cell_countdown == 16'd0);
        in_term = (a * 64'(cell_cfg.input_rise)) >> 16;
        if (!expired)
        begin
            cell_countdown = cell_countdown - 16'd1;
        end
        if (!cell_cfg.model_mode)
        begin
            if (cell_st != CELL_QUIET)
            begin
                if (expired)
                begin
                    cell_st = CELL_QUIET;
                    cell_exc = 0;
                end
            end
            else
            begin
                leak_toward(a);
                if (cell_exc >= cell_thr)
                begin
                    cell_st = CELL_PULSE;
                    cell_countdown = cell_cfg.pulse_ticks;
                end
            end
            settle_threshold((cell_st != CELL_QUIET) ?
                             64'(cell_cfg.pulse_rise) + in_term : 64'd0);
        end
        else
        begin
            leak_toward(a);
            above = (cell_exc >= cell_thr);
            case (cell_st)
                CELL_PULSE:
                begin
                    if (expired)
                    begin
                        cell_st = above ? CELL_BURST : CELL_QUIET;
                        cell_countdown = 16'(HOLD_TICKS);
                    end
                end
                CELL_BURST:
                begin
                    if (!above)
                    begin
                        cell_st = CELL_QUIET;
                    end
                    else if (expired)
                    begin
                        cell_st = CELL_PULSE;
                        cell_countdown = cell_cfg.pulse_ticks;
                    end
                end
                default:
                begin
                    if (above)
                    begin
                        if (expired)
                        begin
                            cell_st = CELL_PULSE;
                            cell_countdown = cell_cfg.pulse_ticks;
                        end
                        else
                        begin
                            cell_st = CELL_BURST;
                        end
                    end
                end
            endcase
            rise = 0;
            if (cell_st == CELL_PULSE)
            begin
                rise = 64'(cell_cfg.pulse_rise) + in_term;
            end
            else if (cell_st == CELL_BURST)
            begin
                rise = in_term;
            end
            cell_pend = clip_value(cell_pend + rise);
            feed = (cell_pend < 64'(cell_cfg.feed_step)) ? cell_pend
                                                         : 64'(cell_cfg.feed_step);
            cell_pend = cell_pend - feed;
            settle_threshold(feed);
        end
        r.cell_state = cell_st;
        r.state_changed = (cell_st != prior);
        r.excitation_out = cell_exc[OUT_VAL_W-1:0];
        r.threshold_out = cell_thr[OUT_VAL_W-1:0];
        return r;
    endfunction

    function automatic cfg_t make_cfg(logic mode, logic [15:0] gain, logic [15:0] pulse,
                                      logic [15:0] decay, logic [15:0] prise,
                                      logic [15:0] irise, logic [15:0] feed);
        cfg_t c;
        c.model_mode = mode;
        c.exc_gain = gain;
        c.pulse_ticks = pulse;
        c.decay_step = decay;
        c.pulse_rise = prise;
        c.input_rise = irise;
        c.feed_step = feed;
        return c;
    endfunction

    function automatic void check_tick_result();
        res_t got;
        res_t want;
        got.cell_state = result_ch.cell_state;
        got.state_changed = result_ch.state_changed;
        got.excitation_out = result_ch.excitation_out;
        got.threshold_out = result_ch.threshold_out;
        if (predicted_ticks.size() == 0)
        begin
            tick_mismatches++;
            if (tick_mismatches <= 10)
            begin
                $display("unexpected result transaction: state %0d excitation %06h threshold %06h",
                         got.cell_state, got.excitation_out, got.threshold_out);
            end
            return;
        end
        want = predicted_ticks.pop_front();
        if (got.cell_state !== want.cell_state || got.state_changed !== want.state_changed ||
            got.excitation_out !== want.excitation_out ||
            got.threshold_out !== want.threshold_out)
        begin
            tick_mismatches++;
            if (tick_mismatches <= 10)
            begin
                $display("tick mismatch (expected/actual): state %0d/%0d changed %0b/%0b",
                         want.cell_state, got.cell_state, want.state_changed,
                         got.state_changed);
                $display("    excitation %06h/%06h threshold %06h/%06h",
                         want.excitation_out, got.excitation_out,
                         want.threshold_out, got.threshold_out);
            end
        end
    endfunction

    task automatic drain_results();
        ach_ch.valid <= 1'b0;
        do @(posedge clk); while (predicted_ticks.size() != 0);
    endtask

    task automatic put_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge clk);
    endtask

    task automatic apply_config(cfg_t c, logic [23:0] init_thr);
        drain_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        put_reg(CFG_MODEL_MODE, CFG_DATA_W'(c.model_mode));
        put_reg(CFG_EXC_GAIN, CFG_DATA_W'(c.exc_gain));
        put_reg(CFG_PULSE_TICKS, CFG_DATA_W'(c.pulse_ticks));
        put_reg(CFG_DECAY_STEP, CFG_DATA_W'(c.decay_step));
        put_reg(CFG_PULSE_RISE, CFG_DATA_W'(c.pulse_rise));
        put_reg(CFG_INPUT_RISE, CFG_DATA_W'(c.input_rise));
        put_reg(CFG_FEED_STEP, CFG_DATA_W'(c.feed_step));
        // The core ignores this write; the one reset loads a fixed threshold.
        put_reg(CFG_INITIAL_THRESHOLD, init_thr);
        cfg_we <= 1'b0;
        cell_cfg = c;
        @(posedge clk);
    endtask

    task automatic send_tick(logic [ACH_W-1:0] ach);
        int gap;
        gap = tx_steady ? 0 : $urandom_range(0, 11);
        if (gap > 0)
        begin
            ach_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        ach_ch.valid <= 1'b1;
        ach_ch.ach_input <= ach;
        do @(posedge clk); while (!ach_ch.ready);
        predicted_ticks.push_back(advance_cell(ach));
    endtask

    // Input is driven in segments: mostly levels close to the current
    // threshold, so that the cell keeps crossing it, plus quiet, full-scale
    // and fully random stretches.
    task automatic run_ticks(int count);
        int               left;
        int               seg;
        int               kind;
        longint unsigned  span;
        longint unsigned  level;
        logic [ACH_W-1:0] ach;
        left = count;
        while (left > 0)
        begin
            seg = $urandom_range(1, 24);
            if (seg > left)
            begin
                seg = left;
            end
            kind = $urandom_range(0, 9);
            if ($urandom_range(0, 3) == 0)
            begin
                tx_steady = !tx_steady;
            end
            if ($urandom_range(0, 3) == 0)
            begin
                rx_steady = !rx_steady;
            end
            repeat (seg)
            begin
                span = 64'($urandom_range(0, 65535));
                if (kind <= 5)
                begin
                    if ($urandom_range(0, 1) == 1)
                    begin
                        level = cell_thr + span;
                    end
                    else
                    begin
                        level = (cell_thr > span) ? cell_thr - span : 64'd0;
                    end
                    ach = (level > 64'(ACH_MAX)) ? ACH_MAX : level[ACH_W-1:0];
                end
                else if (kind == 6)
                begin
                    ach = ACH_W'(span >> 8);
                end
                else if (kind == 7)
                begin
                    ach = ACH_MAX;
                end
                else
                begin
                    ach = ACH_W'($urandom);
                end
                send_tick(ach);
            end
            left -= seg;
        end
    endtask

    task automatic test_base_pulse_cycle();
        apply_config(make_cfg(1'b0, 16'hFFFF, 16'd2, 16'd16, 16'd655, 16'd0, 16'd655),
                     24'hFFFFFF);
        repeat (4) send_tick(ACH_MAX);
        send_tick('0);
    endtask

    task automatic test_burst_cycle();
        apply_config(make_cfg(1'b1, 16'hFFFF, 16'd0, 16'd16, 16'd655, 16'd0, 16'd0), 24'd0);
        send_tick(ACH_MAX);
        send_tick(ACH_MAX);
        send_tick(ACH_MAX);
        send_tick('0);
        send_tick(ACH_MAX);
        send_tick('0);
    endtask

    task automatic test_pending_saturation();
        apply_config(make_cfg(1'b1, 16'hFFFF, 16'd3, 16'd0, 16'hFFFF, 16'hFFFF, 16'd0),
                     INIT_THRESHOLD_RESET);
        repeat (5) send_tick(ACH_MAX);
    endtask

    task automatic test_threshold_saturation();
        apply_config(make_cfg(1'b0, 16'hFFFF, 16'd4, 16'd0, 16'hFFFF, 16'hFFFF, 16'd0),
                     24'd1);
        repeat (6) send_tick(ACH_MAX);
    endtask

    task automatic test_threshold_decay_to_zero();
        apply_config(make_cfg(1'b0, 16'd6554, 16'd8, 16'hFFFF, 16'd0, 16'd0, 16'hFFFF),
                     24'($urandom));
        repeat (300) send_tick(ACH_W'($urandom_range(0, 65535)));
    endtask

    task automatic test_random_settings();
        for (int p = 0; p < 5; p++)
        begin
            apply_config(make_cfg(p[0], 16'($urandom_range(0, 65535)),
                                  16'($urandom_range(0, 30)), 16'($urandom_range(0, 4000)),
                                  16'($urandom_range(0, 65535)), 16'($urandom_range(0, 8000)),
                                  16'($urandom_range(0, 65535))),
                         24'($urandom));
            run_ticks(130);
        end
    endtask

    task automatic test_backpressure();
        tx_steady = 1'b1;
        rx_hold_cycles = 48;
        repeat (40) send_tick(ACH_W'($urandom));
        tx_steady = 1'b0;
    endtask

    task automatic test_drain_pause();
        run_ticks(12);
        drain_results();
        run_ticks(12);
    endtask

    task automatic test_extreme_settings();
        apply_config(make_cfg(1'b0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0), 24'd0);
        run_ticks(80);
        apply_config(make_cfg(1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                              16'hFFFF), 24'hFFFFFF);
        run_ticks(80);
    endtask

    initial
    begin : result_sink
        int hold;
        result_ch.ready = 1'b0;
        do @(posedge clk); while (!rst_n);
        forever
        begin
            if (rx_hold_cycles > 0)
            begin
                hold = rx_hold_cycles;
                rx_hold_cycles = 0;
            end
            else
            begin
                hold = rx_steady ? 0 : $urandom_range(0, 11);
            end
            if (hold > 0)
            begin
                result_ch.ready <= 1'b0;
                repeat (hold) @(posedge clk);
            end
            result_ch.ready <= 1'b1;
            do @(posedge clk); while (!result_ch.valid);
            check_tick_result();
        end
    end

    initial
    begin : watchdog
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = CFG_MODEL_MODE;
        cfg_wdata = '0;
        ach_ch.valid = 1'b0;
        ach_ch.ach_input = '0;
        tx_steady = 1'b0;
        rx_steady = 1'b0;
        rx_hold_cycles = 0;
        tick_mismatches = 0;
        cell_cfg = make_cfg(1'b0, 16'd6554, 16'd100, 16'd16, 16'd655, 16'd655, 16'd655);
        cell_st = CELL_QUIET;
        cell_exc = 0;
        cell_thr = 64'(INIT_THRESHOLD_RESET);
        cell_pend = 0;
        cell_countdown = 16'd0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_base_pulse_cycle();
        test_burst_cycle();
        test_pending_saturation();
        test_threshold_saturation();
        test_threshold_decay_to_zero();
        test_random_settings();
        test_backpressure();
        test_drain_pause();
        test_extreme_settings();

        drain_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (tick_mismatches == 0 && predicted_ticks.size() == 0)
        begin
            $display("[ OK ] regression clean");
        end
        else
        begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

FILE: files.f
+incdir+design
design/atn_pkg.sv
design/atn_ach_if.sv
design/atn_result_if.sv
design/atn_cfg_regs.sv
design/atn_neuron.sv
design/adaptive_threshold_neuron_step_core.sv
design/atn_checker.sv
bench/tb_adaptive_threshold_neuron_step_core.sv
